>>> rtl/gregorian_calendar_date_functions_core_defines.svh
// Assertion macros for the Gregorian date core.
// Included by the top level; no other dependencies.
`ifndef GREGORIAN_CALENDAR_DATE_FUNCTIONS_CORE_DEFINES_SVH
`define GREGORIAN_CALENDAR_DATE_FUNCTIONS_CORE_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define GCDF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The condition must never hold outside reset.
`define GCDF_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

>>> rtl/gcdf_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date core.
// No dependencies; used by every module of the block.
`default_nettype none

package gcdf_pkg;

   // Largest year accepted as valid.
   localparam int MAX_YEAR = 9999;

   // Number of register stages from input to output.
   localparam int STAGES = 6;

   // Reciprocal constants for division by constants.
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int DIV7_MUL     = 18725;
   localparam int DIV7_SHIFT   = 17;
   localparam int WEEK_MUL     = 586;
   localparam int WEEK_SHIFT   = 12;

   // Per-date values handed from the front end to the back end.
   typedef struct packed {
      logic        valid;
      logic        leap;
      logic [4:0]  dim;
      logic [8:0]  ord;
      logic [4:0]  day;
      logic [21:0] day_num;
      logic [14:0] wsum;
   } front_type;

   // One result transaction.
   typedef struct packed {
      logic               first_valid;
      logic               second_valid;
      logic               is_leap_year;
      logic [4:0]         days_in_month;
      logic [8:0]         ordinal_day;
      logic [2:0]         weekday_sunday_based;
      logic [2:0]         weekday_iso;
      logic [2:0]         week_in_month;
      logic [5:0]         iso_week_number;
      logic signed [22:0] day_difference;
   } result_type;

   // Length of a month, index 0 is January.
   function automatic logic [4:0] month_len(input logic [3:0] mi, input logic leap);
      logic [4:0] n;
      unique case (mi)
         4'd1:    n = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

   // Days before the month in a common year.
   function automatic logic [8:0] cum_common(input logic [3:0] mi);
      logic [8:0] c;
      unique case (mi)
         4'd0:    c = 9'd0;
         4'd1:    c = 9'd31;
         4'd2:    c = 9'd59;
         4'd3:    c = 9'd90;
         4'd4:    c = 9'd120;
         4'd5:    c = 9'd151;
         4'd6:    c = 9'd181;
         4'd7:    c = 9'd212;
         4'd8:    c = 9'd243;
         4'd9:    c = 9'd273;
         4'd10:   c = 9'd304;
         4'd11:   c = 9'd334;
         default: c = 9'd0;
      endcase
      return c;
   endfunction

   // Month offset of the Sunday-based weekday sum.
   function automatic logic [2:0] sun_offset(input logic [3:0] mi);
      logic [2:0] o;
      unique case (mi)
         4'd1, 4'd5:  o = 3'd3;
         4'd2, 4'd10: o = 3'd2;
         4'd3, 4'd6:  o = 3'd5;
         4'd7:        o = 3'd1;
         4'd8, 4'd11: o = 3'd4;
         4'd9:        o = 3'd6;
         default:     o = 3'd0;
      endcase
      return o;
   endfunction

endpackage

`default_nettype wire

>>> rtl/gregorian_calendar_date_functions_core.sv
// Top level of the Gregorian date core: stream ports, pipeline control,
// two date front ends and the back end. Depends on gcdf_pkg and all gcdf_ modules.
//
// Usage: each request transaction carries two dates (day, month, year). The
// response transaction reports, for the first date, validity, leap flag,
// month length, ordinal day, Sunday-based and ISO weekday, week of month
// and week of year, plus validity of the second date and the signed day
// difference second minus first. Fields of an invalid first date read zero.
// The six register stages split the reciprocal divisions by 100 and by 7
// from their corrections. Throughput is one transaction per cycle while
// rsp_tready is high. When rsp_tready is low the waiting result holds and
// stages behind it keep filling; req_tready drops only once every stage is
// occupied. Synchronous reset empties the pipeline; no transaction is lost
// or repeated across a stall.
`default_nettype none
`include "gregorian_calendar_date_functions_core_defines.svh"

module gregorian_calendar_date_functions_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request: date_day[4:0], date_month[8:5], date_year[22:9],
   // later_day[27:23], later_month[31:28], later_year[45:32], zero pad above.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,
   // Response: first_valid[0], second_valid[1], is_leap_year[2],
   // days_in_month[7:3], ordinal_day[16:8], weekday_sunday_based[19:17],
   // weekday_iso[22:20], week_in_month[25:23], iso_week_number[31:26],
   // day_difference[54:32], zero pad above.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata
);

   logic [gcdf_pkg::STAGES-1:0] stage_en;
   gcdf_pkg::front_type         first_front;
   gcdf_pkg::front_type         second_front;
   gcdf_pkg::result_type        rsp;

   // Handshake and per-stage load enables.
   gcdf_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .stage_en  (stage_en)
   );

   // First date front end.
   gcdf_date_front u_front_first (
      .clock    (clock),
      .stage_en (stage_en[2:0]),
      .day      (req_tdata[4:0]),
      .month    (req_tdata[8:5]),
      .year     (req_tdata[22:9]),
      .front    (first_front)
   );

   // Second date front end.
   gcdf_date_front u_front_second (
      .clock    (clock),
      .stage_en (stage_en[2:0]),
      .day      (req_tdata[27:23]),
      .month    (req_tdata[31:28]),
      .year     (req_tdata[45:32]),
      .front    (second_front)
   );

   // Weekday, weeks and difference.
   gcdf_date_back u_back (
      .clock    (clock),
      .stage_en (stage_en[5:3]),
      .first    (first_front),
      .second   (second_front),
      .result   (rsp)
   );

   // Pack the result transaction.
   assign rsp_tdata = {1'b0, rsp.day_difference, rsp.iso_week_number, rsp.week_in_month,
                       rsp.weekday_iso, rsp.weekday_sunday_based, rsp.ordinal_day,
                       rsp.days_in_month, rsp.is_leap_year, rsp.second_valid,
                       rsp.first_valid};

   // Checks on the result and on pipeline occupancy.
   `GCDF_ASSERT_IMPL(a_invalid_first_zero, clock, reset, rsp_tvalid && !rsp.first_valid, rsp_tdata[55:2] == 54'd0, "derived fields of an invalid first date are not zero")
   `GCDF_ASSERT_IMPL(a_weekday_pair, clock, reset, rsp_tvalid && rsp.first_valid, (rsp.weekday_iso != 3'd0) && ((rsp.weekday_iso == 3'd7) == (rsp.weekday_sunday_based == 3'd0)), "ISO and Sunday-based weekdays disagree")
   `GCDF_ASSERT_IMPL(a_ordinal_range, clock, reset, rsp_tvalid && rsp.first_valid, (rsp.ordinal_day != 9'd0) && (rsp.ordinal_day <= 9'd365 + 9'(rsp.is_leap_year)), "ordinal day out of range")
   `GCDF_ASSERT_NEVER(a_stall_source, clock, reset, !req_tready && !(rsp_tvalid && !rsp_tready), "request stalled while the response side is free")

endmodule

`default_nettype wire

>>> rtl/gcdf_pipe_ctrl.sv
// Valid bits and per-stage load enables of the date pipeline.
// Depends on gcdf_pkg for the stage count.
`default_nettype none

module gcdf_pipe_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [gcdf_pkg::STAGES-1:0]      stage_en
);

   logic [gcdf_pkg::STAGES-1:0] valid_ff;
   logic [gcdf_pkg::STAGES-1:0] valid_in;

   // A stage loads when it is empty or its content moves on; bubbles collapse.
   always_comb begin
      stage_en[gcdf_pkg::STAGES-1] = !valid_ff[gcdf_pkg::STAGES-1] || out_ready;
      for (int k = gcdf_pkg::STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   // Valid bits follow the data they belong to.
   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = in_valid;
      end
      for (int k = 1; k < gcdf_pkg::STAGES; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[gcdf_pkg::STAGES-1];

endmodule

`default_nettype wire

>>> rtl/gcdf_date_front.sv
// Front end for one date: validity, leap flag, ordinal day, day number
// and the raw weekday sum over three register stages. Depends on gcdf_pkg.
`default_nettype none

module gcdf_date_front (
   input  wire logic                 clock,
   input  wire logic [2:0]           stage_en,
   input  wire logic [4:0]           day,
   input  wire logic [3:0]           month,
   input  wire logic [13:0]          year,
   output gcdf_pkg::front_type       front
);

   // Stage 1: range checks and the shifted year.
   logic [14:0] sy_s1_in;
   logic [3:0]  mi_s1_in;
   logic        yok_s1_in;
   logic        mok_s1_in;
   logic [4:0]  day_s1_ff;
   logic [3:0]  mi_s1_ff;
   logic [13:0] year_s1_ff;
   logic [14:0] sy_s1_ff;
   logic        yok_s1_ff;
   logic        mok_s1_ff;

   always_comb begin
      sy_s1_in  = {1'b0, year} + 15'd400 - {14'd0, (month < 4'd3)};
      mi_s1_in  = month - 4'd1;
      yok_s1_in = year <= 14'(gcdf_pkg::MAX_YEAR);
      mok_s1_in = (month >= 4'd1) && (month <= 4'd12);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         day_s1_ff  <= day;
         mi_s1_ff   <= mi_s1_in;
         year_s1_ff <= year;
         sy_s1_ff   <= sy_s1_in;
         yok_s1_ff  <= yok_s1_in;
         mok_s1_ff  <= mok_s1_in;
      end
   end

   // Stage 2: quotients by 100 through reciprocal products, and year * 365.
   logic [27:0] c_prod;
   logic [26:0] q_prod;
   logic [22:0] y365_s2_in;
   logic [7:0]  c_s2_ff;
   logic [7:0]  q_s2_ff;
   logic [22:0] y365_s2_ff;
   logic [4:0]  day_s2_ff;
   logic [3:0]  mi_s2_ff;
   logic [13:0] year_s2_ff;
   logic [14:0] sy_s2_ff;
   logic        yok_s2_ff;
   logic        mok_s2_ff;

   always_comb begin
      c_prod     = 28'(sy_s1_ff) * 28'(gcdf_pkg::DIV100_MUL);
      q_prod     = 27'(year_s1_ff) * 27'(gcdf_pkg::DIV100_MUL);
      y365_s2_in = 23'(year_s1_ff) * 23'd365;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         c_s2_ff    <= c_prod[gcdf_pkg::DIV100_SHIFT+7:gcdf_pkg::DIV100_SHIFT];
         q_s2_ff    <= q_prod[gcdf_pkg::DIV100_SHIFT+7:gcdf_pkg::DIV100_SHIFT];
         y365_s2_ff <= y365_s2_in;
         day_s2_ff  <= day_s1_ff;
         mi_s2_ff   <= mi_s1_ff;
         year_s2_ff <= year_s1_ff;
         sy_s2_ff   <= sy_s1_ff;
         yok_s2_ff  <= yok_s1_ff;
         mok_s2_ff  <= mok_s1_ff;
      end
   end

   // Stage 3: leap flag, month length, validity, leap-day count and sums.
   logic [13:0] r100;
   logic        r_zero;
   logic        leap;
   logic [4:0]  dim;
   logic [8:0]  cum;
   logic [12:0] leap_cnt;
   gcdf_pkg::front_type front_in;
   gcdf_pkg::front_type front_ff;

   always_comb begin
      r100     = year_s2_ff - (14'(q_s2_ff) * 14'd100);
      r_zero   = (r100 == 14'd0);
      leap     = ((year_s2_ff[1:0] == 2'd0) && !r_zero) || (r_zero && (q_s2_ff[1:0] == 2'd0));
      dim      = gcdf_pkg::month_len(mi_s2_ff, leap);
      cum      = gcdf_pkg::cum_common(mi_s2_ff);
      leap_cnt = sy_s2_ff[14:2] - 13'(c_s2_ff) + 13'(c_s2_ff[7:2]);

      front_in.valid   = yok_s2_ff && mok_s2_ff && (day_s2_ff != 5'd0) && (day_s2_ff <= dim);
      front_in.leap    = leap;
      front_in.dim     = dim;
      front_in.ord     = cum + 9'(day_s2_ff) + 9'(leap && (mi_s2_ff >= 4'd2));
      front_in.day     = day_s2_ff;
      front_in.day_num = 22'(y365_s2_ff) + 22'(day_s2_ff) + 22'(cum) + 22'(leap_cnt);
      front_in.wsum    = sy_s2_ff + 15'(leap_cnt) + 15'(gcdf_pkg::sun_offset(mi_s2_ff))
                       + 15'(day_s2_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

`default_nettype wire

>>> rtl/gcdf_date_back.sv
// Back end: weekday modulo 7, ISO weekday, week numbers and day
// difference over three register stages. Depends on gcdf_pkg.
`default_nettype none

module gcdf_date_back (
   input  wire logic                 clock,
   input  wire logic [2:0]           stage_en,
   input  wire gcdf_pkg::front_type  first,
   input  wire gcdf_pkg::front_type  second,
   output gcdf_pkg::result_type      result
);

   // Stage 4: weekday quotient by 7 and the signed day difference.
   logic [29:0]        wq_prod;
   logic signed [22:0] diff_s4_in;
   logic [12:0]        wq_s4_ff;
   logic signed [22:0] diff_s4_ff;
   gcdf_pkg::front_type first_s4_ff;
   logic               sv_s4_ff;

   always_comb begin
      wq_prod = 30'(first.wsum) * 30'(gcdf_pkg::DIV7_MUL);
      if (first.valid && second.valid) begin
         diff_s4_in = signed'(23'(second.day_num) - 23'(first.day_num));
      end else begin
         diff_s4_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         wq_s4_ff    <= wq_prod[gcdf_pkg::DIV7_SHIFT+12:gcdf_pkg::DIV7_SHIFT];
         diff_s4_ff  <= diff_s4_in;
         first_s4_ff <= first;
         sv_s4_ff    <= second.valid;
      end
   end

   // Stage 5: remainder gives the weekday; week numerators follow.
   logic [14:0]        wrem;
   logic [2:0]         wsun_s5_in;
   logic [2:0]         wiso_s5_in;
   logic [5:0]         xm_s5_in;
   logic [8:0]         xy_s5_in;
   logic [2:0]         wsun_s5_ff;
   logic [2:0]         wiso_s5_ff;
   logic [5:0]         xm_s5_ff;
   logic [8:0]         xy_s5_ff;
   logic signed [22:0] diff_s5_ff;
   gcdf_pkg::front_type first_s5_ff;
   logic               sv_s5_ff;

   always_comb begin
      wrem       = first_s4_ff.wsum - (15'(wq_s4_ff) * 15'd7);
      wsun_s5_in = wrem[2:0];
      wiso_s5_in = (wsun_s5_in == 3'd0) ? 3'd7 : wsun_s5_in;
      xm_s5_in   = 6'(first_s4_ff.day) + 6'd10 - 6'(wiso_s5_in);
      xy_s5_in   = first_s4_ff.ord + 9'd10 - 9'(wiso_s5_in);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         wsun_s5_ff  <= wsun_s5_in;
         wiso_s5_ff  <= wiso_s5_in;
         xm_s5_ff    <= xm_s5_in;
         xy_s5_ff    <= xy_s5_in;
         diff_s5_ff  <= diff_s4_ff;
         first_s5_ff <= first_s4_ff;
         sv_s5_ff    <= sv_s4_ff;
      end
   end

   // Stage 6: week quotients by 7 and zeroing of an invalid first date.
   logic [15:0] wm_prod;
   logic [18:0] wy_prod;
   gcdf_pkg::result_type result_in;
   gcdf_pkg::result_type result_ff;

   always_comb begin
      wm_prod = 16'(xm_s5_ff) * 16'(gcdf_pkg::WEEK_MUL);
      wy_prod = 19'(xy_s5_ff) * 19'(gcdf_pkg::WEEK_MUL);
      result_in = '0;
      result_in.first_valid  = first_s5_ff.valid;
      result_in.second_valid = sv_s5_ff;
      if (first_s5_ff.valid) begin
         result_in.is_leap_year         = first_s5_ff.leap;
         result_in.days_in_month        = first_s5_ff.dim;
         result_in.ordinal_day          = first_s5_ff.ord;
         result_in.weekday_sunday_based = wsun_s5_ff;
         result_in.weekday_iso          = wiso_s5_ff;
         result_in.week_in_month        =
            wm_prod[gcdf_pkg::WEEK_SHIFT+2:gcdf_pkg::WEEK_SHIFT];
         result_in.iso_week_number      =
            wy_prod[gcdf_pkg::WEEK_SHIFT+5:gcdf_pkg::WEEK_SHIFT];
         result_in.day_difference       = diff_s5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire
